// ===== hw/rtl/fp32m_pkg.sv =====
// Shared constants and helpers for the single-precision multiplier.
package fp32m_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned SIG_W  = 24;
    localparam int unsigned PROD_W = 48;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

    typedef struct packed {
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic [9:0]  exp_sum;
        logic [SIG_W-1:0] sig_a;
        logic [SIG_W-1:0] sig_b;
    } t_unpacked;

    function automatic logic [4:0] lead_zeros24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction
endpackage

// ===== hw/rtl/fp32_multiplier.sv =====
// Top level of the single-precision multiplier.
// IEEE 754 binary32 multiplier, round to nearest even, full subnormal support.
// Input channel: i_valid/o_ready with i_operand_a and i_operand_b.
// Output channel: o_valid/i_ready with o_product.
// A transaction is accepted when valid and ready are both high.
// The product passes stage one and stage two before o_valid rises.
// Stage one unpacks operands and forms the 24x24 significand product;
// stage two normalizes, rounds and packs into the output register.
// Throughput: one transaction per cycle while i_ready stays high; the 24x24
// multiply sets the stage one path and the rounding adder the stage two path.
// NaN inputs or infinity times zero give quiet NaN 0x7FC00000.
// When the receiver stalls, the pipeline holds; o_ready falls only when
// both stages are full and the output is not taken.
// Reset (synchronous, active low) empties both stages.
module fp32_multiplier
    import fp32m_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_product
);
    logic              r_v1, r_v2;
    logic              r_sign, r_special;
    logic [31:0]       r_special_bits, r_product;
    logic signed [9:0] r_exp;
    logic [PROD_W-1:0] r_prod;
    logic              adv2, adv1;
    logic [31:0]       n_special_bits, rounded;
    logic              n_special;
    logic signed [9:0] n_exp;
    logic [23:0]       sa, sb;
    logic signed [9:0] ea, eb;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_product = r_product;

    function automatic logic is_nan(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    always_comb begin
        logic        sg;
        logic [4:0]  za, zb;
        sg = i_operand_a[31] ^ i_operand_b[31];
        za = lead_zeros24({1'b0, i_operand_a[22:0]});
        zb = lead_zeros24({1'b0, i_operand_b[22:0]});
        if (i_operand_a[30:23] == 8'd0) begin
            sa = {1'b0, i_operand_a[22:0]} << za;
            ea = 10'sd1 - 10'(za);
        end else begin
            sa = {1'b1, i_operand_a[22:0]};
            ea = 10'(i_operand_a[30:23]);
        end
        if (i_operand_b[30:23] == 8'd0) begin
            sb = {1'b0, i_operand_b[22:0]} << zb;
            eb = 10'sd1 - 10'(zb);
        end else begin
            sb = {1'b1, i_operand_b[22:0]};
            eb = 10'(i_operand_b[30:23]);
        end
        n_exp = ea + eb - 10'sd127;
        n_special = 1'b1;
        if (is_nan(i_operand_a) || is_nan(i_operand_b)) begin
            n_special_bits = QNAN_BITS;
        end else if (i_operand_a[30:0] == INF_BITS[30:0]
                     || i_operand_b[30:0] == INF_BITS[30:0]) begin
            if (i_operand_a[30:0] == 31'd0 || i_operand_b[30:0] == 31'd0) begin
                n_special_bits = QNAN_BITS;
            end else begin
                n_special_bits = {sg, INF_BITS[30:0]};
            end
        end else if (i_operand_a[30:0] == 31'd0 || i_operand_b[30:0] == 31'd0) begin
            n_special_bits = {sg, 31'd0};
        end else begin
            n_special_bits = '0;
            n_special = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_sign         <= i_operand_a[31] ^ i_operand_b[31];
            r_special      <= n_special;
            r_special_bits <= n_special_bits;
            r_exp          <= n_exp;
            r_prod         <= sa * sb;
        end
        if (adv2 && r_v1) begin
            r_product <= r_special ? r_special_bits : rounded;
        end
    end

    fp32m_round u_round (
        .i_sign (r_sign),
        .i_exp  (r_exp),
        .i_prod (r_prod),
        .o_bits (rounded)
    );
endmodule

// ===== hw/rtl/fp32m_round.sv =====
// Normalize, denormalize and round a 48-bit significand product.
module fp32m_round
    import fp32m_pkg::*;
(
    input  logic              i_sign,
    input  logic signed [9:0] i_exp,
    input  logic [PROD_W-1:0] i_prod,
    output logic [31:0]       o_bits
);
    logic [PROD_W-1:0] p;
    logic [PROD_W-1:0] lost_mask;
    logic signed [9:0] e;
    logic [9:0]        sh;
    logic [23:0]       m;
    logic [23:0]       rnd;
    logic [24:0]       m_r;
    logic [32:0]       bits;

    always_comb begin
        if (i_prod[PROD_W-1]) begin
            p = i_prod;
            e = i_exp + 10'sd1;
        end else begin
            p = {i_prod[PROD_W-2:0], 1'b0};
            e = i_exp;
        end
        sh = 10'(10'sd1 - e);
        lost_mask = '0;
        if (e <= 10'sd0) begin
            if (sh >= 10'd48) begin
                p = {47'd0, |p};
            end else begin
                lost_mask = (48'd1 << sh[5:0]) - 48'd1;
                p = (p >> sh[5:0]) | {47'd0, |(p & lost_mask)};
            end
            e = 10'sd1;
        end
        m   = p[47:24];
        rnd = p[23:0];
        m_r = {1'b0, m};
        if (rnd > 24'h80_0000 || (rnd == 24'h80_0000 && m[0])) begin
            m_r = m_r + 25'd1;
        end
        bits = {10'(e - 10'sd1), 23'd0} + {8'd0, m_r};
        if (e >= 10'sd255 || bits >= {1'b0, INF_BITS}) begin
            o_bits = {i_sign, INF_BITS[30:0]};
        end else begin
            o_bits = {i_sign, bits[30:0]};
        end
    end
endmodule

// ===== bench/fp32_multiplier_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the single-precision multiplier: predicted products checked in order.
module fp32_multiplier_tb
    import fp32m_pkg::*;
;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_product;

    fp32_multiplier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_product   (o_product)
    );

    logic [63:0] pending_pairs[$];
    logic [31:0] expected_products[$];
    int          mismatch_count;
    bit          stim_done;
    bit          sender_pause;
    bit          receiver_hold;
    int          send_wait;
    int          recv_wait;

    function automatic bit is_nan_bits(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    function automatic logic [31:0] fmul_predict(logic [31:0] a, logic [31:0] b);
        logic        sgn;
        logic [23:0] sig_a;
        logic [23:0] sig_b;
        int          exp_a;
        int          exp_b;
        int          exp_r;
        int          sh;
        logic [63:0] prod;
        logic [63:0] lost;
        logic [31:0] mant;
        logic [31:0] rem;
        logic [31:0] bits;
        sgn = a[31] ^ b[31];
        if (is_nan_bits(a) || is_nan_bits(b)) return QNAN_BITS;
        if (a[30:0] == INF_BITS[30:0] || b[30:0] == INF_BITS[30:0]) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return QNAN_BITS;
            return {sgn, INF_BITS[30:0]};
        end
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
        sig_a = {a[30:23] != 8'd0, a[22:0]};
        exp_a = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        while (!sig_a[23]) begin
            sig_a = sig_a << 1;
            exp_a--;
        end
        sig_b = {b[30:23] != 8'd0, b[22:0]};
        exp_b = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        while (!sig_b[23]) begin
            sig_b = sig_b << 1;
            exp_b--;
        end
        prod = 64'(sig_a) * 64'(sig_b);
        if (prod[47]) begin
            exp_r = exp_a + exp_b - 126;
        end else begin
            prod = prod << 1;
            exp_r = exp_a + exp_b - 127;
        end
        if (exp_r >= 255) return {sgn, INF_BITS[30:0]};
        if (exp_r <= 0) begin
            sh = 1 - exp_r;
            if (sh >= 48) begin
                prod = (prod != 0) ? 64'd1 : 64'd0;
            end else begin
                lost = prod & ((64'd1 << sh) - 64'd1);
                prod = (prod >> sh) | 64'(lost != 0);
            end
            exp_r = 1;
        end
        mant = 32'(prod >> 24);
        rem = {8'd0, prod[23:0]};
        if (rem > 32'h80_0000 || (rem == 32'h80_0000 && mant[0])) mant = mant + 1;
        bits = (32'(exp_r - 1) << 23) + mant;
        if (bits >= INF_BITS) return {sgn, INF_BITS[30:0]};
        return {sgn, bits[30:0]};
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 9))
            0: x[30:23] = 8'd0;
            1: x[30:23] = 8'hFF;
            2: x[30:23] = 8'($urandom_range(0, 20));
            3: x[30:23] = 8'($urandom_range(235, 254));
            4: x[22:0] = ($urandom_range(0, 1)) ? 23'd0 : 23'h7F_FFFF;
            5: x[30:0] = 31'($urandom_range(0, 3));
            default: x[30:23] = 8'($urandom_range(64, 190));
        endcase
        return x;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        logic [31:0] dir_vals[12];
        dir_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'hFF80_0001, 32'h0000_0001, 32'h007F_FFFF,
                     32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hBFFF_FFFF};
        for (int k = 0; k < 12; k++) begin
            pending_pairs.push_back({dir_vals[k], dir_vals[(k * 5 + 3) % 12]});
        end
        pending_pairs.push_back({32'h3F00_0000, 32'h0000_0001});
        pending_pairs.push_back({32'h3F40_0000, 32'h0000_0001});
        pending_pairs.push_back({32'h3F80_0001, 32'h3F7F_FFFF});
        pending_pairs.push_back({32'h3FFF_FFFF, 32'h3FFF_FFFF});
        pending_pairs.push_back({32'h7F00_0000, 32'h4000_0000});
        pending_pairs.push_back({32'hFFFF_FFFF, 32'h3F80_0000});
        pending_pairs.push_back({32'h7F80_0000, 32'h8000_0000});
        pending_pairs.push_back({32'h1F80_0000, 32'h2000_0000});
        for (int k = 0; k < 740; k++) begin
            pending_pairs.push_back({rand_operand(), rand_operand()});
        end
    end

    initial begin
        #2000000;
        $display("fp32_multiplier_tb failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_operand_a <= '0;
            i_operand_b <= '0;
            send_wait <= 0;
            sender_pause <= 1'b0;
        end else if (sender_pause) begin
            if (i_valid && o_ready) begin
                i_valid <= 1'b0;
            end else if (!i_valid && expected_products.size() == 0) begin
                sender_pause <= 1'b0;
            end
        end else if (i_valid && !o_ready) begin
        end else if (send_wait > 0) begin
            i_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (pending_pairs.size() > 0) begin
            {i_operand_a, i_operand_b} <= pending_pairs.pop_front();
            i_valid <= 1'b1;
            send_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            if (pending_pairs.size() == 300) sender_pause <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_products.push_back(fmul_predict(i_operand_a, i_operand_b));
            if (pending_pairs.size() == 0 && !sender_pause) stim_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [31:0] exp_p;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_wait <= 0;
            receiver_hold <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_products.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected product %h", o_product);
                end else begin
                    exp_p = expected_products.pop_front();
                    if (exp_p !== o_product) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("product mismatch: expected %h actual %h",
                                     exp_p, o_product);
                    end
                end
            end
            if (recv_wait > 0) begin
                i_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end else if (!receiver_hold && pending_pairs.size() <= 600) begin
                receiver_hold <= 1'b1;
                i_ready <= 1'b0;
                recv_wait <= 200;
            end else if (o_valid && i_ready) begin
                i_ready <= 1'b0;
                recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && !i_valid && expected_products.size() == 0))
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_products.size() == 0)
            $display("fp32_multiplier_tb passed");
        else
            $display("fp32_multiplier_tb failed");
        $finish;
    end
endmodule
